[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is held
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// clocked assertion that also covers reset cycles
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

[sv/cnms_pkg.sv]
// ----------------------------------------------------------------------------
// cnms_pkg
// types and constants of the canny non-maximum suppression block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cnms_pkg;

    localparam int MAG_W        = 8;
    localparam int DIR_W        = 2;
    localparam int COL_W        = 11;
    localparam int ROW_W        = 12;
    localparam int FW_CFG_W     = 12;
    localparam int FH_CFG_W     = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_IDX_W    = 1;

    localparam int FRAME_WIDTH_RST  = 640;
    localparam int FRAME_HEIGHT_RST = 480;

    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    typedef enum logic [DIR_W-1:0] {
        DIR_0   = 2'd0,
        DIR_45  = 2'd1,
        DIR_90  = 2'd2,
        DIR_135 = 2'd3
    } t_dir;

    typedef struct packed {
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
        logic             frame_end;
    } t_tag;

    typedef struct packed {
        logic [MAG_W-1:0] kept_value;
        t_tag             tag;
    } t_result;

endpackage

`default_nettype wire

[sv/canny_non_max_suppression_top.sv]
// ----------------------------------------------------------------------------
// canny_non_max_suppression_top
// streaming 3x3 non-maximum suppression over gradient magnitude and direction
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) takes one pixel per unstalled cycle in
//   raster order: magnitude and quantized direction. Output channel (o_valid /
//   i_stall) gives one item per interior pixel with its kept value, column,
//   row and a frame_end flag on the last interior pixel of the frame.
//   The pixel at row r, column c releases the item for (r-1, c-1) once both
//   are at least 2; other pixels produce no item.
//   Items pass the line store read register, the window and the result queue.
//   Throughput: 1 pixel per cycle while o_stall is low, set by the line store
//   read on acceptance and its write, on a separate port, in the next cycle.
//   Frame sizes are written on the cfg port while the block is idle; values
//   below 3 act as 3, values above MAX_WIDTH / MAX_HEIGHT act as the maximum.
//   Reset clears the counters, window and result queue; the line stores hold
//   whatever they held and need no clearing pass.
//   When the receiver stalls, results collect in a 4-entry queue; o_stall
//   rises once the queue plus items in flight could fill it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module canny_non_max_suppression_top #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [cnms_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [cnms_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [cnms_pkg::MAG_W-1:0]      i_magnitude,
    input  wire logic [cnms_pkg::DIR_W-1:0]      i_direction,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic      [cnms_pkg::MAG_W-1:0]      o_kept_value,
    output logic      [cnms_pkg::COL_W-1:0]      o_column,
    output logic      [cnms_pkg::ROW_W-1:0]      o_row,
    output logic                                 o_frame_end
);
    import cnms_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int WCW  = CW + 1;
    localparam int HCW  = RW + 1;
    localparam int SW   = $clog2(FIFO_DEPTH + 3);
    localparam int W_RST = (FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST;
    localparam int H_RST = (FRAME_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_HEIGHT_RST;

    logic [WCW-1:0]   r_width;
    logic [WCW-1:0]   n_width;
    logic [HCW-1:0]   r_height;
    logic [HCW-1:0]   n_height;
    logic [FW_CFG_W-1:0] w_fw_raw;
    logic [FH_CFG_W-1:0] w_fh_raw;

    logic [CW-1:0]    r_col;
    logic [CW-1:0]    n_col;
    logic [RW-1:0]    r_row;
    logic [RW-1:0]    n_row;
    logic             w_accept;
    logic             w_col_last;
    logic             w_row_last;
    logic             w_emit;
    t_tag             w_tag;

    logic             r_p1_valid;
    logic             r_p1_emit;
    t_tag             r_p1_tag;
    logic [CW-1:0]    r_p1_col;
    logic [MAG_W-1:0] r_p1_mag;
    logic [DIR_W-1:0] r_p1_dir;
    logic             r_p2_valid;
    t_tag             r_p2_tag;

    logic [MAG_W-1:0] w_rd_top;
    logic [MAG_W-1:0] w_rd_mid;
    logic [DIR_W-1:0] w_rd_dir;
    logic [MAG_W-1:0] w_kept;
    t_result          w_push_data;
    t_result          w_head;
    logic [FIFO_CNT_W-1:0] w_count;
    logic [SW-1:0]    w_load;

    // size registers, stored already clamped
    assign w_fw_raw = i_cfg_data[FW_CFG_W-1:0];
    assign w_fh_raw = i_cfg_data[FH_CFG_W-1:0];

    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH: begin
                    if (32'(w_fw_raw) < 32'd3) begin
                        n_width = WCW'(3);
                    end else if (32'(w_fw_raw) > 32'(MAX_WIDTH)) begin
                        n_width = WCW'(MAX_WIDTH);
                    end else begin
                        n_width = WCW'(w_fw_raw);
                    end
                end
                CFG_FRAME_HEIGHT: begin
                    if (32'(w_fh_raw) < 32'd3) begin
                        n_height = HCW'(3);
                    end else if (32'(w_fh_raw) > 32'(MAX_HEIGHT)) begin
                        n_height = HCW'(MAX_HEIGHT);
                    end else begin
                        n_height = HCW'(w_fh_raw);
                    end
                end
                default: begin
                    n_width  = r_width;
                    n_height = r_height;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WCW'(W_RST);
            r_height <= HCW'(H_RST);
        end else begin
            r_width  <= n_width;
            r_height <= n_height;
        end
    end

    // raster position
    assign w_accept   = i_valid && !o_stall;
    assign w_col_last = ({1'b0, r_col} + 1'b1) >= r_width;
    assign w_row_last = ({1'b0, r_row} + 1'b1) >= r_height;
    assign w_emit     = (r_col >= CW'(2)) && (r_row >= RW'(2));

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (w_accept) begin
            if (w_col_last) begin
                n_col = '0;
                n_row = w_row_last ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_comb begin
        w_tag.column    = COL_W'(32'(r_col) - 32'd1);
        w_tag.row       = ROW_W'(32'(r_row) - 32'd1);
        w_tag.frame_end = w_col_last && w_row_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_p1_valid <= w_accept;
            r_p2_valid <= r_p1_valid && r_p1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_p1_emit <= w_emit;
            r_p1_tag  <= w_tag;
            r_p1_col  <= r_col;
            r_p1_mag  <= i_magnitude;
            r_p1_dir  <= i_direction;
        end
        r_p2_tag <= r_p1_tag;
    end

    cnms_line_buf #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_rd_en   (w_accept),
        .i_rd_addr (r_col),
        .i_wr_en   (r_p1_valid),
        .i_wr_addr (r_p1_col),
        .i_wr_mag  (r_p1_mag),
        .i_wr_dir  (r_p1_dir),
        .o_rd_top  (w_rd_top),
        .o_rd_mid  (w_rd_mid),
        .o_rd_dir  (w_rd_dir)
    );

    cnms_window u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_shift      (r_p1_valid),
        .i_top        (w_rd_top),
        .i_mid        (w_rd_mid),
        .i_mag        (r_p1_mag),
        .i_dir        (w_rd_dir),
        .o_kept_value (w_kept)
    );

    assign w_push_data.kept_value = w_kept;
    assign w_push_data.tag        = r_p2_tag;

    cnms_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_p2_valid),
        .i_data  (w_push_data),
        .i_pop   (!i_stall),
        .o_valid (o_valid),
        .o_data  (w_head),
        .o_count (w_count)
    );

    // queue entries plus items still in flight
    assign w_load  = SW'(w_count) + SW'(r_p1_valid) + SW'(r_p2_valid);
    assign o_stall = (w_load >= SW'(FIFO_DEPTH));

    assign o_kept_value = w_head.kept_value;
    assign o_column     = w_head.tag.column;
    assign o_row        = w_head.tag.row;
    assign o_frame_end  = w_head.tag.frame_end;

endmodule

`default_nettype wire

[sv/cnms_line_buf.sv]
// ----------------------------------------------------------------------------
// cnms_line_buf
// upper, middle and direction line stores with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cnms_line_buf #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rd_en,
    input  wire logic [AW-1:0]              i_rd_addr,
    input  wire logic                       i_wr_en,
    input  wire logic [AW-1:0]              i_wr_addr,
    input  wire logic [cnms_pkg::MAG_W-1:0] i_wr_mag,
    input  wire logic [cnms_pkg::DIR_W-1:0] i_wr_dir,
    output logic      [cnms_pkg::MAG_W-1:0] o_rd_top,
    output logic      [cnms_pkg::MAG_W-1:0] o_rd_mid,
    output logic      [cnms_pkg::DIR_W-1:0] o_rd_dir
);
    import cnms_pkg::*;

    logic [MAG_W-1:0] r_upper  [DEPTH];
    logic [MAG_W-1:0] r_middle [DEPTH];
    logic [DIR_W-1:0] r_dirs   [DEPTH];

    logic [MAG_W-1:0] r_rd_top;
    logic [MAG_W-1:0] r_rd_mid;
    logic [DIR_W-1:0] r_rd_dir;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_top <= r_upper[i_rd_addr];
            r_rd_mid <= r_middle[i_rd_addr];
            r_rd_dir <= r_dirs[i_rd_addr];
        end
    end

    // middle row moves up, new pixel enters the middle row
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_upper[i_wr_addr]  <= r_rd_mid;
            r_middle[i_wr_addr] <= i_wr_mag;
            r_dirs[i_wr_addr]   <= i_wr_dir;
        end
    end

    assign o_rd_top = r_rd_top;
    assign o_rd_mid = r_rd_mid;
    assign o_rd_dir = r_rd_dir;

endmodule

`default_nettype wire

[sv/cnms_window.sv]
// ----------------------------------------------------------------------------
// cnms_window
// 3x3 magnitude window, center direction and the suppression compare
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cnms_window (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_shift,
    input  wire logic [cnms_pkg::MAG_W-1:0] i_top,
    input  wire logic [cnms_pkg::MAG_W-1:0] i_mid,
    input  wire logic [cnms_pkg::MAG_W-1:0] i_mag,
    input  wire logic [cnms_pkg::DIR_W-1:0] i_dir,
    output logic      [cnms_pkg::MAG_W-1:0] o_kept_value
);
    import cnms_pkg::*;

    logic [MAG_W-1:0] r_win [9];
    logic [MAG_W-1:0] n_win [9];
    t_dir             r_cdir [2];
    t_dir             n_cdir [2];
    logic [MAG_W-1:0] w_a;
    logic [MAG_W-1:0] w_b;
    logic [MAG_W-1:0] w_cur;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            n_win[k] = r_win[k];
        end
        n_cdir[0] = r_cdir[0];
        n_cdir[1] = r_cdir[1];
        if (i_shift) begin
            for (int k = 0; k < 3; k++) begin
                n_win[k*3]     = r_win[k*3 + 1];
                n_win[k*3 + 1] = r_win[k*3 + 2];
            end
            n_win[2]  = i_top;
            n_win[5]  = i_mid;
            n_win[8]  = i_mag;
            n_cdir[0] = r_cdir[1];
            n_cdir[1] = t_dir'(i_dir);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
            r_cdir[0] <= DIR_0;
            r_cdir[1] <= DIR_0;
        end else begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= n_win[k];
            end
            r_cdir[0] <= n_cdir[0];
            r_cdir[1] <= n_cdir[1];
        end
    end

    // neighbors along the gradient direction
    always_comb begin
        case (r_cdir[0])
            DIR_0: begin
                w_a = r_win[3];
                w_b = r_win[5];
            end
            DIR_45: begin
                w_a = r_win[2];
                w_b = r_win[6];
            end
            DIR_90: begin
                w_a = r_win[1];
                w_b = r_win[7];
            end
            DIR_135: begin
                w_a = r_win[0];
                w_b = r_win[8];
            end
            default: begin
                w_a = r_win[3];
                w_b = r_win[5];
            end
        endcase
    end

    assign w_cur        = r_win[4];
    assign o_kept_value = (w_cur >= w_a && w_cur >= w_b) ? w_cur : '0;

endmodule

`default_nettype wire

[sv/cnms_out_fifo.sv]
// ----------------------------------------------------------------------------
// cnms_out_fifo
// small result queue that decouples the pipeline from output stall
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cnms_out_fifo (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_push,
    input  wire cnms_pkg::t_result               i_data,
    input  wire logic                            i_pop,
    output logic                                 o_valid,
    output cnms_pkg::t_result                    o_data,
    output logic [cnms_pkg::FIFO_CNT_W-1:0]      o_count
);
    import cnms_pkg::*;

    t_result               r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic [FIFO_CNT_W-1:0] n_count;
    logic                  w_pop;

    assign w_pop = i_pop && (r_count != '0);

    always_comb begin
        n_count = r_count;
        if (i_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && w_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

`default_nettype wire

[sv/cnms_checker.sv]
// ----------------------------------------------------------------------------
// cnms_checker
// port-level checks of the non-maximum suppression top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module cnms_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_valid,
    input wire logic                            o_stall,
    input wire logic                            o_valid,
    input wire logic                            i_stall,
    input wire logic [cnms_pkg::MAG_W-1:0]      o_kept_value,
    input wire logic [cnms_pkg::COL_W-1:0]      o_column,
    input wire logic [cnms_pkg::ROW_W-1:0]      o_row,
    input wire logic                            o_frame_end
);
    import cnms_pkg::*;

    logic [MAG_W+COL_W+ROW_W:0] w_payload;

    assign w_payload = {o_kept_value, o_column, o_row, o_frame_end};

    // output queue is empty after reset
    `ASSERT_ALWAYS(a_empty_after_reset, !i_rst_n |=> !o_valid, "item shown after reset")

    // a first item needs an earlier accepted input pixel
    `ASSERT_CLK(a_latency, $rose(o_valid) |-> $past(i_valid && !o_stall, 3), "item from nowhere")

    `ASSERT_CLK(a_valid_holds, o_valid && i_stall |=> o_valid, "item dropped under stall")

    `ASSERT_CLK(a_payload_holds, o_valid && i_stall |=> $stable(w_payload), "item changed")

endmodule

bind canny_non_max_suppression_top cnms_checker u_cnms_checker (.*);

`default_nettype wire
